/* sv/ecri_pkg.sv */
// Shared types, constants and register codes for the ellipse center-ray intersect block.
package ecri_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    localparam logic [30:0] AXIS_ONE = 31'd1 << FRAC_BITS;

    // Register indexes (word address)
    localparam logic [1:0] REG_CX = 2'd0;
    localparam logic [1:0] REG_CY = 2'd1;
    localparam logic [1:0] REG_AX = 2'd2;
    localparam logic [1:0] REG_AY = 2'd3;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } point_t;

    typedef struct packed {
        logic               hit_valid;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
    } hit_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] ax;
        logic [30:0] ay;
    } cfg_t;

    // Classified item between front and back
    typedef struct packed {
        logic [31:0] dxm;
        logic [31:0] dym;
        logic        up;
        logic        inv;
    } mid_t;

    // Fields carried alongside the final divide
    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic        up;
        logic        inv;
    } fin_t;

    // Fields carried alongside the square root
    typedef struct packed {
        fin_t        fin;
        logic [61:0] au;
        logic [61:0] bv;
    } sq_side_t;

endpackage

/* sv/ecri_front.sv */
// Front part: classifies each point against the center and queues it for the back part.
module ecri_front
    import ecri_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   push,
    input  point_t point,
    output logic   full,
    input  logic   mid_pop,
    output logic   mid_empty,
    output mid_t   mid
);

    logic [32:0] dx;
    logic [32:0] dy;
    mid_t        cls;
    mid_t        q_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic        wr;

    // Offsets from the center, magnitudes and direction of the hit
    always_comb
    begin
        dx = {point.point_x[31], point.point_x} - {cfg.cx[31], cfg.cx};
        dy = {point.point_y[31], point.point_y} - {cfg.cy[31], cfg.cy};
        cls.dxm = dx[32] ? 32'(-dx) : dx[31:0];
        cls.dym = dy[32] ? 32'(-dy) : dy[31:0];
        cls.up  = dx[32] ? dy[32] : (!dy[32] && (dy != 33'd0));
        cls.inv = (dx == 33'd0) && (dy == 33'd0);
    end

    // Short queue toward the back part
    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign mid_empty = (cnt_reg == '0);
    assign mid       = q_mem[rd_ptr_reg];
    assign wr        = push && !full;

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = mid_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(wr) - QCNT_W'(mid_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* sv/ecri_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ecri_isqrt
    import ecri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [62:0] n_in,
    input  sq_side_t    side_in,
    output logic        out_valid,
    output logic [31:0] r_out,
    output sq_side_t    side_out
);

    logic [SQRT_STAGES-1:0] vld_reg;
    logic [63:0] n_reg  [0:SQRT_STAGES-1];
    logic [63:0] r_reg  [0:SQRT_STAGES-1];
    logic [63:0] n_next [0:SQRT_STAGES-1];
    logic [63:0] r_next [0:SQRT_STAGES-1];
    sq_side_t    side_reg [0:SQRT_STAGES-1];

    // One compare and subtract per stage
    always_comb
    begin
        logic [63:0] ncur;
        logic [63:0] rcur;
        logic [63:0] bitv;
        logic [63:0] t;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            ncur = (k == 0) ? {1'b0, n_in} : n_reg[(k == 0) ? 0 : k - 1];
            rcur = (k == 0) ? 64'd0 : r_reg[(k == 0) ? 0 : k - 1];
            bitv = 64'd1 << (62 - 2 * k);
            t    = rcur + bitv;
            if (ncur >= t)
            begin
                n_next[k] = ncur - t;
                r_next[k] = (rcur >> 1) + bitv;
            end
            else
            begin
                n_next[k] = ncur;
                r_next[k] = rcur >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                n_reg[k]    <= n_next[k];
                r_reg[k]    <= r_next[k];
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign r_out     = r_reg[SQRT_STAGES-1][31:0];
    assign side_out  = side_reg[SQRT_STAGES-1];

endmodule

/* sv/ecri_div.sv */
// Pipelined restoring divider for the x and y offsets, one quotient bit per stage.
module ecri_div
    import ecri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] num_x,
    input  logic [63:0] num_y,
    input  logic [32:0] den,
    input  fin_t        side_in,
    output logic        out_valid,
    output logic [31:0] ox,
    output logic [31:0] oy,
    output fin_t        side_out
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [32:0] remx_reg [0:DIV_STAGES-1];
    logic [32:0] remy_reg [0:DIV_STAGES-1];
    logic [31:0] lox_reg  [0:DIV_STAGES-1];
    logic [31:0] loy_reg  [0:DIV_STAGES-1];
    logic [31:0] qx_reg   [0:DIV_STAGES-1];
    logic [31:0] qy_reg   [0:DIV_STAGES-1];
    logic [32:0] den_reg  [0:DIV_STAGES-1];
    fin_t        side_reg [0:DIV_STAGES-1];
    logic [32:0] remx_next [0:DIV_STAGES-1];
    logic [32:0] remy_next [0:DIV_STAGES-1];
    logic [31:0] qx_next   [0:DIV_STAGES-1];
    logic [31:0] qy_next   [0:DIV_STAGES-1];

    // Shift in one numerator bit, subtract the divisor where it fits
    always_comb
    begin
        logic [32:0] rx;
        logic [32:0] ry;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [32:0] d;
        logic [33:0] tx;
        logic [33:0] ty;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rx = {1'b0, num_x[63:32]};
                ry = {1'b0, num_y[63:32]};
                lx = num_x[31:0];
                ly = num_y[31:0];
                qx = '0;
                qy = '0;
                d  = den;
            end
            else
            begin
                rx = remx_reg[(k == 0) ? 0 : k - 1];
                ry = remy_reg[(k == 0) ? 0 : k - 1];
                lx = lox_reg[(k == 0) ? 0 : k - 1];
                ly = loy_reg[(k == 0) ? 0 : k - 1];
                qx = qx_reg[(k == 0) ? 0 : k - 1];
                qy = qy_reg[(k == 0) ? 0 : k - 1];
                d  = den_reg[(k == 0) ? 0 : k - 1];
            end
            tx = {rx, lx[31]};
            ty = {ry, ly[31]};
            if (tx >= {1'b0, d})
            begin
                remx_next[k] = 33'(tx - {1'b0, d});
                qx_next[k]   = {qx[30:0], 1'b1};
            end
            else
            begin
                remx_next[k] = tx[32:0];
                qx_next[k]   = {qx[30:0], 1'b0};
            end
            if (ty >= {1'b0, d})
            begin
                remy_next[k] = 33'(ty - {1'b0, d});
                qy_next[k]   = {qy[30:0], 1'b1};
            end
            else
            begin
                remy_next[k] = ty[32:0];
                qy_next[k]   = {qy[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                remx_reg[k] <= remx_next[k];
                remy_reg[k] <= remy_next[k];
                qx_reg[k]   <= qx_next[k];
                qy_reg[k]   <= qy_next[k];
                if (k == 0)
                begin
                    lox_reg[k]  <= {num_x[30:0], 1'b0};
                    loy_reg[k]  <= {num_y[30:0], 1'b0};
                    den_reg[k]  <= den;
                    side_reg[k] <= side_in;
                end
                else
                begin
                    lox_reg[k]  <= {lox_reg[(k == 0) ? 0 : k - 1][30:0], 1'b0};
                    loy_reg[k]  <= {loy_reg[(k == 0) ? 0 : k - 1][30:0], 1'b0};
                    den_reg[k]  <= den_reg[(k == 0) ? 0 : k - 1];
                    side_reg[k] <= side_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign ox        = qx_reg[DIV_STAGES-1];
    assign oy        = qy_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

/* sv/ecri_back.sv */
// Back part: scales the direction, takes its length, divides out the offsets, queues results.
module ecri_back
    import ecri_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic mid_empty,
    input  mid_t mid,
    output logic mid_pop,
    output logic empty,
    input  logic pop,
    output hit_t hit
);

    logic en;

    // Stage 1: direction scaled by the opposite semi-axis
    logic        s1_vld_reg;
    logic [62:0] s1_u_reg, s1_v_reg;
    logic [30:0] s1_a_reg, s1_b_reg;
    fin_t        s1_fin_reg;
    logic [30:0] a_eff, b_eff;
    fin_t        fin_in;

    // Stage 2: leading one of the larger component
    logic        s2_vld_reg;
    logic [62:0] s2_u_reg, s2_v_reg;
    logic [30:0] s2_a_reg, s2_b_reg;
    fin_t        s2_fin_reg;
    logic        s2_right_reg, s2_right_next;
    logic [5:0]  s2_amt_reg, s2_amt_next;
    logic [62:0] m_max;
    logic [5:0]  msb;

    // Stage 3: normalized components
    logic        s3_vld_reg;
    logic [30:0] s3_un_reg, s3_vn_reg;
    logic [30:0] s3_a_reg, s3_b_reg;
    fin_t        s3_fin_reg;
    logic [62:0] un_full, vn_full;

    // Stage 4: squares and semi-axis products
    logic        s4_vld_reg;
    logic [61:0] s4_usq_reg, s4_vsq_reg, s4_au_reg, s4_bv_reg;
    fin_t        s4_fin_reg;

    // Stage 5: sum of squares
    logic        s5_vld_reg;
    logic [62:0] s5_n_reg;
    sq_side_t    s5_side_reg;

    // Square root
    logic        sq_vld;
    logic [31:0] sq_r;
    sq_side_t    sq_side;

    // Stage 6: numerators and divisor
    logic        s6_vld_reg;
    logic [63:0] s6_numx_reg, s6_numy_reg;
    logic [32:0] s6_den_reg;
    fin_t        s6_fin_reg;

    // Divider
    logic        dv_vld;
    logic [31:0] dv_ox, dv_oy;
    fin_t        dv_fin;

    // Result queue
    hit_t        res;
    hit_t        oq_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] oq_wr_reg, oq_wr_next, oq_rd_reg, oq_rd_next;
    logic [QCNT_W-1:0] oq_cnt_reg, oq_cnt_next;
    logic        oq_push, oq_pop;
    logic [33:0] sum_x, sum_y;

    function automatic logic [31:0] sat34(input logic [33:0] s);
        logic [31:0] r;
        if (s[33] != s[31] || s[32] != s[31])
        begin
            r = s[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Whole pipeline advances while the result queue has room
    assign en      = (oq_cnt_reg < QCNT_W'(QDEPTH));
    assign mid_pop = en && !mid_empty;

    always_comb
    begin
        a_eff      = (cfg.ax == '0) ? 31'd1 : cfg.ax;
        b_eff      = (cfg.ay == '0) ? 31'd1 : cfg.ay;
        fin_in.cx  = cfg.cx;
        fin_in.cy  = cfg.cy;
        fin_in.up  = mid.up;
        fin_in.inv = mid.inv;
    end

    // Shift needed to bring the larger component into [2^30, 2^31)
    always_comb
    begin
        m_max = (s1_u_reg > s1_v_reg) ? s1_u_reg : s1_v_reg;
        msb   = '0;
        for (int i = 0; i < 63; i++)
        begin
            if (m_max[i])
            begin
                msb = 6'(i);
            end
        end
        s2_right_next = (msb > 6'd30);
        s2_amt_next   = s2_right_next ? msb - 6'd30 : 6'd30 - msb;
    end

    always_comb
    begin
        un_full = s2_right_reg ? (s2_u_reg >> s2_amt_reg) : (s2_u_reg << s2_amt_reg);
        vn_full = s2_right_reg ? (s2_v_reg >> s2_amt_reg) : (s2_v_reg << s2_amt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= !mid_empty;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg     <= mid.dxm * b_eff;
            s1_v_reg     <= mid.dym * a_eff;
            s1_a_reg     <= a_eff;
            s1_b_reg     <= b_eff;
            s1_fin_reg   <= fin_in;

            s2_u_reg     <= s1_u_reg;
            s2_v_reg     <= s1_v_reg;
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_fin_reg   <= s1_fin_reg;
            s2_right_reg <= s2_right_next;
            s2_amt_reg   <= s2_amt_next;

            s3_un_reg    <= un_full[30:0];
            s3_vn_reg    <= vn_full[30:0];
            s3_a_reg     <= s2_a_reg;
            s3_b_reg     <= s2_b_reg;
            s3_fin_reg   <= s2_fin_reg;

            s4_usq_reg   <= s3_un_reg * s3_un_reg;
            s4_vsq_reg   <= s3_vn_reg * s3_vn_reg;
            s4_au_reg    <= s3_a_reg * s3_un_reg;
            s4_bv_reg    <= s3_b_reg * s3_vn_reg;
            s4_fin_reg   <= s3_fin_reg;

            s5_n_reg        <= {1'b0, s4_usq_reg} + {1'b0, s4_vsq_reg};
            s5_side_reg.fin <= s4_fin_reg;
            s5_side_reg.au  <= s4_au_reg;
            s5_side_reg.bv  <= s4_bv_reg;

            // Rounded half up: (2*a*u + r) / (2*r)
            s6_numx_reg  <= {1'b0, sq_side.au, 1'b0} + {32'd0, sq_r};
            s6_numy_reg  <= {1'b0, sq_side.bv, 1'b0} + {32'd0, sq_r};
            s6_den_reg   <= {sq_r, 1'b0};
            s6_fin_reg   <= sq_side.fin;
        end
    end

    ecri_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_vld_reg),
        .n_in      (s5_n_reg),
        .side_in   (s5_side_reg),
        .out_valid (sq_vld),
        .r_out     (sq_r),
        .side_out  (sq_side)
    );

    ecri_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_vld_reg),
        .num_x     (s6_numx_reg),
        .num_y     (s6_numy_reg),
        .den       (s6_den_reg),
        .side_in   (s6_fin_reg),
        .out_valid (dv_vld),
        .ox        (dv_ox),
        .oy        (dv_oy),
        .side_out  (dv_fin)
    );

    // Offsets applied to the center with saturation
    always_comb
    begin
        sum_x = {{2{dv_fin.cx[31]}}, dv_fin.cx} + {2'b00, dv_ox};
        sum_y = dv_fin.up ? {{2{dv_fin.cy[31]}}, dv_fin.cy} + {2'b00, dv_oy}
                          : {{2{dv_fin.cy[31]}}, dv_fin.cy} - {2'b00, dv_oy};
        if (dv_fin.inv)
        begin
            res.hit_valid = 1'b0;
            res.hit_x     = '0;
            res.hit_y     = '0;
        end
        else
        begin
            res.hit_valid = 1'b1;
            res.hit_x     = sat34(sum_x);
            res.hit_y     = sat34(sum_y);
        end
    end

    // Result queue
    assign oq_push = en && dv_vld;
    assign empty   = (oq_cnt_reg == '0);
    assign oq_pop  = pop && !empty;
    assign hit     = oq_mem[oq_rd_reg];

    always_comb
    begin
        oq_wr_next  = oq_push ? oq_wr_reg + 1'b1 : oq_wr_reg;
        oq_rd_next  = oq_pop ? oq_rd_reg + 1'b1 : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + QCNT_W'(oq_push) - QCNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= res;
        end
    end

endmodule

/* sv/ellipse_center_ray_intersect.sv */
// Top level: configuration registers, front and back parts of the ellipse intersect block.
//
// Each point pushed in yields one result: the intersection with larger x of the line through
// the configured ellipse center and the point, in signed Q16.16, rounded and saturated, with
// hit_valid low (and zero coordinates) when the point equals the center. The block takes one
// point per cycle while full is low; each point passes five staging registers ahead of the
// 32-stage square-root pipeline, one staging register, the 32-stage divider pipeline and the
// write into the result queue. Points wait in a four-entry queue behind the front part and
// results in a four-entry queue at the output; the back pipeline holds while the result queue
// is full, and full rises once the input queue fills. Write the registers only while no point
// is in flight.
module ellipse_center_ray_intersect
    import ecri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  point_t      point,
    output logic        empty,
    input  logic        pop,
    output hit_t        hit
);

    logic [31:0] cx_reg, cy_reg;
    logic [30:0] ax_reg, ay_reg;
    logic        cfg_wr;
    cfg_t        cfg;
    logic        mid_pop, mid_empty;
    mid_t        mid;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            ax_reg <= AXIS_ONE;
            ay_reg <= AXIS_ONE;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_CX:  cx_reg <= pwdata;
                REG_CY:  cy_reg <= pwdata;
                REG_AX:  ax_reg <= pwdata[30:0];
                REG_AY:  ay_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CX:  prdata = cx_reg;
            REG_CY:  prdata = cy_reg;
            REG_AX:  prdata = {1'b0, ax_reg};
            REG_AY:  prdata = {1'b0, ay_reg};
            default: prdata = '0;
        endcase
    end

    assign cfg.cx = cx_reg;
    assign cfg.cy = cy_reg;
    assign cfg.ax = ax_reg;
    assign cfg.ay = ay_reg;

    ecri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .point     (point),
        .full      (full),
        .mid_pop   (mid_pop),
        .mid_empty (mid_empty),
        .mid       (mid)
    );

    ecri_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_empty (mid_empty),
        .mid       (mid),
        .mid_pop   (mid_pop),
        .empty     (empty),
        .pop       (pop),
        .hit       (hit)
    );

    // An invalid result carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit.hit_valid) |-> (hit.hit_x == 32'sd0 && hit.hit_y == 32'sd0))
        else $error("invalid result with nonzero coordinates");

    // A center x write lands in its register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[3:2] == REG_CX) |=> (cx_reg == $past(pwdata)))
        else $error("center x write lost");

    // The back part never pulls from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("pull from empty queue");

endmodule

/* tb/ellipse_center_ray_intersect_tb.sv */
// Testbench for the ellipse center-ray intersect block: directed table, random points, hit prediction.
`timescale 1ns / 100ps

module ellipse_center_ray_intersect_tb;
    import ecri_pkg::*;

    localparam int N_RANDOM    = 700;
    localparam int DRAIN_WAIT  = 120;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    point_t      point;
    logic        empty;
    logic        pop;
    hit_t        hit;

    // Predictor's copy of the ellipse registers
    logic [31:0] ell_cx;
    logic [31:0] ell_cy;
    logic [30:0] ell_ax;
    logic [30:0] ell_ay;

    hit_t   hit_queue[$];
    int     err_count;
    int     cycle_count;
    bit     quiet_phase;
    bit     hold_pop;
    bit     hold_req;

    // Directed table row: point, and an optional typed-in expected hit
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        bit          fixed;
        hit_t        want;
    } dir_row_t;

    ellipse_center_ray_intersect u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .point(point), .empty(empty), .pop(pop), .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t timeout", $time);
                $display("[ellipse_center_ray_intersect] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Expected intersection for one point
    function automatic hit_t predict_hit(logic [31:0] px, logic [31:0] py);
        logic signed [63:0] cx, cy, dx, dy;
        logic [63:0] a, b, u, v, m, r, ox, oy;
        bit up;
        hit_t h;
        cx = {{32{ell_cx[31]}}, ell_cx};
        cy = {{32{ell_cy[31]}}, ell_cy};
        dx = {{32{px[31]}}, px} - cx;
        dy = {{32{py[31]}}, py} - cy;
        a  = (ell_ax == 0) ? 64'd1 : {33'd0, ell_ax};
        b  = (ell_ay == 0) ? 64'd1 : {33'd0, ell_ay};
        h  = '0;
        if (dx == 0 && dy == 0)
            return h;
        u = (dx < 0 ? -dx : dx) * b;
        v = (dy < 0 ? -dy : dy) * a;
        m = (u > v) ? u : v;
        while (m >= (64'd1 << 31))
        begin
            u = u >> 1;
            v = v >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 30))
        begin
            u = u << 1;
            v = v << 1;
            m = m << 1;
        end
        r  = int_sqrt(u * u + v * v);
        ox = (2 * a * u + r) / (2 * r);
        oy = (2 * b * v + r) / (2 * r);
        up = (dx >= 0) ? (dy > 0) : (dy < 0);
        h.hit_valid = 1'b1;
        h.hit_x = clamp32(cx + $signed(ox));
        h.hit_y = clamp32(up ? cy + $signed(oy) : cy - $signed(oy));
        return h;
    endfunction

    // Sometimes, outside the quiet phase, an idle burst with push low
    task automatic maybe_idle();
        int n;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 14);
            push <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CX: ell_cx = val;
            REG_CY: ell_cy = val;
            REG_AX: ell_ax = val[30:0];
            default: ell_ay = val[30:0];
        endcase
    endtask

    // Send one point; expectation is queued once full reads low after an edge, push stays up for the next
    task automatic send_point(logic [31:0] px, logic [31:0] py, bit fixed, hit_t want);
        hit_t h;
        maybe_idle();
        point <= {px, py};
        push  <= 1'b1;
        h = fixed ? want : predict_hit(px, py);
        do @(posedge clk); while (full);
        hit_queue.insert(hit_queue.size(), h);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        if (push)
            push <= 1'b0;
        while (hit_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65536 * 4) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h7fffffff;
            2: return $urandom_range(1, 200);
            default: return $urandom & 32'h7fffffff;
        endcase
    endfunction

    // Result side: pop with random stalls and one long hold-off
    initial
    begin
        hit_t exp_h;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pop || (!quiet_phase && $urandom_range(0, 6) == 0))
            begin
                pop <= 1'b0;
                if (!hold_pop)
                    repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            else
                pop <= 1'b1;
            @(posedge clk);
            if (pop && !empty)
            begin
                if (hit_queue.size() == 0)
                begin
                    $display("%0t unexpected hit %h", $time, hit);
                    err_count++;
                end
                else
                begin
                    exp_h = hit_queue.pop_front();
                    if (hit.hit_valid !== exp_h.hit_valid)
                    begin
                        $display("%0t hit_valid exp %b got %b", $time,
                                 exp_h.hit_valid, hit.hit_valid);
                        err_count++;
                    end
                    if (hit.hit_x !== exp_h.hit_x)
                    begin
                        $display("%0t hit_x exp %h got %h", $time, exp_h.hit_x, hit.hit_x);
                        err_count++;
                    end
                    if (hit.hit_y !== exp_h.hit_y)
                    begin
                        $display("%0t hit_y exp %h got %h", $time, exp_h.hit_y, hit.hit_y);
                        err_count++;
                    end
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles, while the sender keeps going
    initial
    begin
        int held;
        hold_pop = 1'b0;
        wait (hold_req);
        hold_pop = 1'b1;
        held = 0;
        while (held < 400)
        begin
            @(posedge clk);
            held++;
        end
        hold_pop = 1'b0;
    end

    initial
    begin
        dir_row_t rows [0:11];
        hit_t     none;
        int       k;
        err_count   = 0;
        quiet_phase = 1'b0;
        hold_req    = 1'b0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        push    = 1'b0;
        point   = '0;
        ell_cx  = 32'd0;
        ell_cy  = 32'd0;
        ell_ax  = AXIS_ONE;
        ell_ay  = AXIS_ONE;
        none    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unit circle after reset
        rows = '{
            '{32'd0, 32'd0, 1'b1, '0},                                       // point at center
            '{32'h00020000, 32'd0, 1'b1, '{1'b1, 32'h00010000, 32'd0}},
            '{32'hfffe0000, 32'd0, 1'b1, '{1'b1, 32'h00010000, 32'd0}},
            '{32'd0, 32'h00050000, 1'b1, '{1'b1, 32'd0, 32'h00010000}},     // vertical up
            '{32'd0, 32'hfffb0000, 1'b1, '{1'b1, 32'd0, 32'hffff0000}},     // vertical down
            '{32'h7fffffff, 32'h7fffffff, 1'b0, '0},
            '{32'h80000000, 32'h80000000, 1'b0, '0},
            '{32'h7fffffff, 32'h80000000, 1'b0, '0},
            '{32'h80000000, 32'h7fffffff, 1'b0, '0},
            '{32'd1, 32'd0, 1'b0, '0},
            '{32'hffffffff, 32'd1, 1'b0, '0},
            '{32'h00010000, 32'hffff0000, 1'b0, '0}
        };
        foreach (rows[i])
            send_point(rows[i].px, rows[i].py, rows[i].fixed, rows[i].want);
        wait_idle();

        // Extreme center and zero axes: saturation and one-LSB axes
        reg_write(REG_CX, 32'h7fff0000);
        reg_write(REG_CY, 32'h80000000);
        reg_write(REG_AX, 32'h7fffffff);
        reg_write(REG_AY, 32'd0);
        send_point(32'h7fff0000, 32'h80000000, 1'b1, '0);
        send_point(32'h7fffffff, 32'h80000001, 1'b0, none);
        send_point(32'h80000000, 32'h7fffffff, 1'b0, none);
        send_point(32'h7fff0000, 32'h7fffffff, 1'b0, none);
        wait_idle();
        reg_write(REG_AX, 32'd0);
        reg_write(REG_AY, 32'h7fffffff);
        send_point(32'h7fff0001, 32'h80000000, 1'b0, none);
        send_point(32'd0, 32'd0, 1'b0, none);
        wait_idle();

        // Random phases, each with new register settings
        for (k = 0; k < N_RANDOM; k++)
        begin
            if (k % 100 == 0)
            begin
                wait_idle();
                reg_write(REG_CX, (k % 200 == 0) ? rand_coord() : 32'd0);
                reg_write(REG_CY, rand_coord());
                reg_write(REG_AX, rand_axis());
                reg_write(REG_AY, rand_axis());
                if (k >= 600)
                    quiet_phase = 1'b1;
            end
            if (k == 101)
                hold_req = 1'b1;
            case ($urandom_range(0, 9))
                0: send_point(ell_cx, ell_cy, 1'b0, none);
                1: send_point(ell_cx, rand_coord(), 1'b0, none);
                2: send_point(ell_cx + $urandom_range(0, 4) - 2, ell_cy + $urandom_range(0, 4) - 2,
                              1'b0, none);
                default: send_point(rand_coord(), rand_coord(), 1'b0, none);
            endcase
        end
        wait_idle();
        if (err_count == 0)
            $display("[ellipse_center_ray_intersect] OK");
        else
            $display("[ellipse_center_ray_intersect] ERROR");
        $finish;
    end

endmodule
